// ===== rtl/ppam_pkg.sv =====
// ----------------------------------------------------------------------------
// ppam_pkg
// Shared types, constants and address helpers for the video bus address map.
// ----------------------------------------------------------------------------
package ppam_pkg;

  localparam int CHR_BANKS  = 16;
  localparam int BANK_SIZE  = 8192;
  localparam int STORE_SIZE = CHR_BANKS * BANK_SIZE;
  localparam int PS_AW      = $clog2(STORE_SIZE);

  localparam int NT_DEPTH  = 2048;
  localparam int NT_AW     = $clog2(NT_DEPTH);
  localparam int PAL_DEPTH = 32;
  localparam int PAL_AW    = $clog2(PAL_DEPTH);

  localparam logic [5:0] PAL_PAGE = 6'h3F;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_LOAD  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_CHR_IS_RAM      = 2'd0,
    REG_CHR_BANK        = 2'd1,
    REG_MIRROR_VERTICAL = 2'd2,
    REG_IGNORE_MIRROR   = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    SEL_PAT = 2'd0,
    SEL_NT  = 2'd1,
    SEL_PAL = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [PS_AW-1:0] addr;
    logic [7:0]       data;
  } pat_req_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic             pal;
    logic [NT_AW-1:0] addr;
    logic [7:0]       data;
  } ntp_req_t;

  // Bank wraps modulo the bank count; the product is a shift by 13.
  function automatic logic [PS_AW-1:0] pat_index(logic [3:0] bank, logic [12:0] low);
    int b;
    b = int'(bank) % CHR_BANKS;
    return PS_AW'(b * BANK_SIZE + int'(low));
  endfunction

  function automatic logic [NT_AW-1:0] nt_fold(logic [13:0] a, logic vert, logic ign);
    logic page;
    page = vert ? a[10] : a[11];
    return ign ? a[10:0] : {page, a[9:0]};
  endfunction

endpackage

// ===== rtl/ppam_pattern_store.sv =====
// ----------------------------------------------------------------------------
// ppam_pattern_store
// Banked pattern byte store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module ppam_pattern_store (
  input  logic              clk_i,
  input  ppam_pkg::pat_req_t req_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem [ppam_pkg::STORE_SIZE];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.data;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ppam_nt_pal.sv =====
// ----------------------------------------------------------------------------
// ppam_nt_pal
// Name-table and palette memories with a zeroing sweep after reset.
// ----------------------------------------------------------------------------
module ppam_nt_pal (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ppam_pkg::ntp_req_t req_i,
  output logic               clearing_o,
  output logic [7:0]         nt_rdata_o,
  output logic [7:0]         pal_rdata_o
);

  logic [7:0] nt_mem  [ppam_pkg::NT_DEPTH];
  logic [7:0] pal_mem [ppam_pkg::PAL_DEPTH];
  logic [7:0] nt_rdata_q;
  logic [7:0] pal_rdata_q;

  logic                       clearing_q;
  logic [ppam_pkg::NT_AW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else if (clearing_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == ppam_pkg::NT_AW'(ppam_pkg::NT_DEPTH - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      nt_mem[clr_q] <= '0;
      if (clr_q < ppam_pkg::NT_AW'(ppam_pkg::PAL_DEPTH)) begin
        pal_mem[clr_q[ppam_pkg::PAL_AW-1:0]] <= '0;
      end
    end else if (req_i.we) begin
      if (req_i.pal) begin
        pal_mem[req_i.addr[ppam_pkg::PAL_AW-1:0]] <= req_i.data;
      end else begin
        nt_mem[req_i.addr] <= req_i.data;
      end
    end
    if (req_i.re) begin
      nt_rdata_q  <= nt_mem[req_i.addr];
      pal_rdata_q <= pal_mem[req_i.addr[ppam_pkg::PAL_AW-1:0]];
    end
  end

  assign clearing_o  = clearing_q;
  assign nt_rdata_o  = nt_rdata_q;
  assign pal_rdata_o = pal_rdata_q;

endmodule

// ===== rtl/ppu_address_space_map.sv =====
// ----------------------------------------------------------------------------
// ppu_address_space_map
// Video bus address decoder over pattern, name-table and palette memories.
// ----------------------------------------------------------------------------
//  channel   ports                                              direction
//  request   start, busy (out), kind_i, addr_i, write_data_i,    in
//            load_index_i
//  result    read_valid_o, read_data_o                          out
//  config    cfg_we_i, cfg_idx_i, cfg_data_i                    in
//
//  One request per cycle while busy is low; a read result appears in the cycle
//  after acceptance, set by the registered read of each memory.
//  After reset busy stays high while all 2048 name-table entries and the
//  palette are swept to zero; config writes are taken throughout.
//  The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module ppu_address_space_map (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [13:0] addr_i,
  input  logic [7:0]  write_data_i,
  input  logic [16:0] load_index_i,
  output logic        read_valid_o,
  output logic [7:0]  read_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [3:0]  cfg_data_i
);

  logic       chr_is_ram_q;
  logic [3:0] chr_bank_q;
  logic       mirror_vertical_q;
  logic       ignore_mirror_q;

  logic              accept;
  logic              in_pat;
  logic              in_pal;
  ppam_pkg::kind_e   kind;
  ppam_pkg::pat_req_t pat_req;
  ppam_pkg::ntp_req_t ntp_req;
  ppam_pkg::rd_sel_e sel_d, sel_q;
  logic              rvalid_d, rvalid_q;
  logic              clearing;
  logic [7:0]        pat_rdata, nt_rdata, pal_rdata;

  assign busy   = clearing;
  assign accept = start && !busy;
  assign kind   = ppam_pkg::kind_e'(kind_i);
  assign in_pat = !addr_i[13];
  assign in_pal = (addr_i[13:8] == ppam_pkg::PAL_PAGE);

  always_comb begin
    pat_req.we   = 1'b0;
    pat_req.re   = 1'b0;
    pat_req.addr = ppam_pkg::pat_index(chr_bank_q, addr_i[12:0]);
    pat_req.data = write_data_i;
    ntp_req.we   = 1'b0;
    ntp_req.re   = 1'b0;
    ntp_req.pal  = in_pal;
    ntp_req.addr = in_pal ? ppam_pkg::NT_AW'(addr_i[4:0])
                          : ppam_pkg::nt_fold(addr_i, mirror_vertical_q, ignore_mirror_q);
    ntp_req.data = write_data_i;
    rvalid_d     = 1'b0;
    sel_d        = in_pat ? ppam_pkg::SEL_PAT : (in_pal ? ppam_pkg::SEL_PAL : ppam_pkg::SEL_NT);
    if (accept) begin
      unique case (kind)
        ppam_pkg::KIND_READ: begin
          rvalid_d   = 1'b1;
          pat_req.re = in_pat;
          ntp_req.re = !in_pat;
        end
        ppam_pkg::KIND_WRITE: begin
          pat_req.we = in_pat && chr_is_ram_q;
          ntp_req.we = !in_pat;
        end
        ppam_pkg::KIND_LOAD: begin
          pat_req.we   = 1'b1;
          pat_req.addr = ppam_pkg::pat_index(load_index_i[16:13], load_index_i[12:0]);
        end
        ppam_pkg::KIND_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chr_is_ram_q      <= 1'b0;
      chr_bank_q        <= '0;
      mirror_vertical_q <= 1'b0;
      ignore_mirror_q   <= 1'b0;
      rvalid_q          <= 1'b0;
      sel_q             <= ppam_pkg::SEL_PAT;
    end else begin
      rvalid_q <= rvalid_d;
      sel_q    <= sel_d;
      if (cfg_we_i) begin
        unique case (ppam_pkg::reg_idx_e'(cfg_idx_i))
          ppam_pkg::REG_CHR_IS_RAM:      chr_is_ram_q      <= cfg_data_i[0];
          ppam_pkg::REG_CHR_BANK:        chr_bank_q        <= cfg_data_i;
          ppam_pkg::REG_MIRROR_VERTICAL: mirror_vertical_q <= cfg_data_i[0];
          ppam_pkg::REG_IGNORE_MIRROR:   ignore_mirror_q   <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  ppam_pattern_store u_pattern_store (
    .clk_i   (clk_i),
    .req_i   (pat_req),
    .rdata_o (pat_rdata)
  );

  ppam_nt_pal u_nt_pal (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (ntp_req),
    .clearing_o  (clearing),
    .nt_rdata_o  (nt_rdata),
    .pal_rdata_o (pal_rdata)
  );

  always_comb begin
    unique case (sel_q)
      ppam_pkg::SEL_PAT: read_data_o = pat_rdata;
      ppam_pkg::SEL_NT:  read_data_o = nt_rdata;
      ppam_pkg::SEL_PAL: read_data_o = pal_rdata;
      default:           read_data_o = pat_rdata;
    endcase
  end

  assign read_valid_o = rvalid_q;

`ifndef SYNTHESIS
  a_result_follows_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_valid_o |-> $past(start && !busy && kind_i == ppam_pkg::KIND_READ))
    else $error("result without an accepted read");

  a_no_result_for_store : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i != ppam_pkg::KIND_READ) |=> !read_valid_o)
    else $error("result after a non-read request");

  a_one_read_port : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i == ppam_pkg::KIND_READ) |-> $onehot({pat_req.re, ntp_req.re}))
    else $error("read must hit exactly one memory");

  a_no_access_when_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !(pat_req.we || pat_req.re || ntp_req.we || ntp_req.re))
    else $error("memory access during clearing sweep");
`endif

endmodule
